// ===== src/assert_macros.svh =====
// Assertion macros shared by the stencil sweep RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define JLS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define JLS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);
`else
`define JLS_ASSERT(label, clk, rst_n, prop, msg)
`define JLS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== src/jls_pkg.sv =====
// Shared constants and types for the Jacobi stencil sweep.
// Used by the line buffer, the window cell and the top level; depends on nothing.
`timescale 1ns / 1ps

package jls_pkg;

    localparam int DEF_LINE_DEPTH = 4096;
    localparam int DEF_VALUE_BITS = 16;

    localparam int COLS_W       = 12;
    localparam int ROWS_W       = 16;
    localparam int ROW_COUNT_W  = 17;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 1;
    localparam int RESET_INTERIOR = 4094;
    localparam int WINDOW_CELLS = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INTERIOR_COLS = 1'b0,
        REG_INTERIOR_ROWS = 1'b1
    } cfg_reg_t;

    // Strobes from the input stage to the line buffer.
    typedef struct packed {
        logic rd_en;  // request accepted: read both lines, write the new cell
        logic wb_en;  // in the cycle after the request: retire the old middle entry upward
    } lb_ctrl_t;

endpackage

// ===== src/jacobi_laplace_stencil_sweep.sv =====
// A result passes the input, stencil and output registers in turn. Throughput: one
// grid cell per cycle while the output skid entry is free; the line memories take
// one read and one write per cycle each, and the window chain shifts once per cell.
// Reset (aresetn, synchronous, active low) clears counters, handshakes and the
// running maximum; the line memories are not cleared and are refilled by rows 0-1.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jacobi_laplace_stencil_sweep #(
    parameter int LINE_DEPTH = jls_pkg::DEF_LINE_DEPTH,
    parameter int VALUE_BITS = jls_pkg::DEF_VALUE_BITS,
    parameter int S_DATA_W   = ((VALUE_BITS + 7) / 8) * 8,
    parameter int M_DATA_W   = ((3 * VALUE_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [jls_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [jls_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input stream: tdata holds cell_value from bit 0, zero padded.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [S_DATA_W-1:0]                s_tdata,
    // Result stream: tdata holds new_value, change, max_change from bit 0 up,
    // zero padded; tlast carries sweep_done.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [M_DATA_W-1:0]                m_tdata,
    output logic                               m_tlast
);

    localparam int ADDR_W  = $clog2(LINE_DEPTH);
    localparam int ROW_W   = jls_pkg::ROW_COUNT_W;
    localparam int CLAMP_W = ((ADDR_W > jls_pkg::COLS_W) ? ADDR_W : jls_pkg::COLS_W) + 1;
    localparam int SUM_W   = VALUE_BITS + 2;
    localparam int RES_W   = 3 * VALUE_BITS + 1;
    localparam int NCELLS  = jls_pkg::WINDOW_CELLS;

    // Reset geometry, saturated to what the line memories can hold.
    localparam int RST_COLS = (jls_pkg::RESET_INTERIOR > LINE_DEPTH - 2)
                              ? (LINE_DEPTH - 2) : jls_pkg::RESET_INTERIOR;
    localparam logic [ADDR_W-1:0] W_LAST_RST = ADDR_W'(RST_COLS + 1);
    localparam logic [ROW_W-1:0]  H_LAST_RST = ROW_W'(jls_pkg::RESET_INTERIOR + 1);

    // ------------------------------------------------------------------
    // Configuration. Only the index of the last column and the last row
    // are kept; both are clamped here so the counters never need to.
    // ------------------------------------------------------------------
    logic                  cfg_write;
    logic [CLAMP_W-1:0]    cols_ext;
    logic [CLAMP_W-1:0]    cols_sat;
    logic [ADDR_W-1:0]     w_last_reg;
    logic [ADDR_W-1:0]     w_last_next;
    logic [ROW_W-1:0]      h_last_reg;
    logic [ROW_W-1:0]      h_last_next;
    logic [jls_pkg::ROWS_W-1:0] rows_val;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        cols_ext = CLAMP_W'(cfg_data[jls_pkg::COLS_W-1:0]);
        if (cols_ext == '0) begin
            cols_sat = CLAMP_W'(1);
        end else if (cols_ext > CLAMP_W'(LINE_DEPTH - 2)) begin
            cols_sat = CLAMP_W'(LINE_DEPTH - 2);
        end else begin
            cols_sat = cols_ext;
        end
        rows_val = cfg_data[jls_pkg::ROWS_W-1:0];

        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg_write) begin
            case (jls_pkg::cfg_reg_t'(cfg_index))
                jls_pkg::REG_INTERIOR_COLS: begin
                    w_last_next = ADDR_W'(cols_sat + CLAMP_W'(1));
                end
                jls_pkg::REG_INTERIOR_ROWS: begin
                    if (rows_val == '0) begin
                        h_last_next = ROW_W'(2);
                    end else begin
                        h_last_next = ROW_W'(rows_val) + ROW_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input stage. The whole pipeline moves whenever the output skid entry
    // is free, so a request is taken even while a result waits at m_tdata.
    // ------------------------------------------------------------------
    logic                  pipe_en;
    logic                  s_accept;
    logic [VALUE_BITS-1:0] cell_value;

    logic [ADDR_W-1:0]     col_count_reg;
    logic [ADDR_W-1:0]     col_count_next;
    logic [ROW_W-1:0]      row_count_reg;
    logic [ROW_W-1:0]      row_count_next;

    logic                  a_valid_reg;
    logic                  a_emit_reg;
    logic                  a_last_reg;
    logic                  a_first_reg;
    logic                  acc_d1_reg;
    logic [VALUE_BITS-1:0] a_cur_reg;
    logic [ADDR_W-1:0]     a_col_reg;

    assign s_tready   = pipe_en;
    assign s_accept   = s_tvalid && s_tready;
    assign cell_value = s_tdata[VALUE_BITS-1:0];

    // Raster counters; a configuration write restarts the sweep.
    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (cfg_write) begin
            col_count_next = '0;
            row_count_next = '0;
        end else if (s_accept) begin
            if (col_count_reg == w_last_reg) begin
                col_count_next = '0;
                if (row_count_reg == h_last_reg) begin
                    row_count_next = '0;
                end else begin
                    row_count_next = row_count_reg + ROW_W'(1);
                end
            end else begin
                col_count_next = col_count_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg    <= W_LAST_RST;
            h_last_reg    <= H_LAST_RST;
            col_count_reg <= '0;
            row_count_reg <= '0;
            a_valid_reg   <= 1'b0;
            acc_d1_reg    <= 1'b0;
        end else begin
            w_last_reg    <= w_last_next;
            h_last_reg    <= h_last_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            acc_d1_reg    <= s_accept;
            if (pipe_en) begin
                a_valid_reg <= s_accept;
            end
        end
    end

    // A request at row r, column c completes the window of the interior cell
    // one row up and one column left, once both r and c are at least two.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_cur_reg   <= cell_value;
            a_col_reg   <= col_count_reg;
            a_emit_reg  <= (row_count_reg >= ROW_W'(2)) && (col_count_reg >= ADDR_W'(2));
            a_last_reg  <= (row_count_reg == h_last_reg) && (col_count_reg == w_last_reg);
            a_first_reg <= (row_count_reg == ROW_W'(2)) && (col_count_reg == ADDR_W'(2));
        end
    end

    // ------------------------------------------------------------------
    // Line memories: the middle line returns the row above, the upper line
    // the row two above, both at the column of the request.
    // ------------------------------------------------------------------
    jls_pkg::lb_ctrl_t     lb_ctrl;
    logic [VALUE_BITS-1:0] mid_rd;
    logic [VALUE_BITS-1:0] up_rd;

    assign lb_ctrl.rd_en = s_accept;
    assign lb_ctrl.wb_en = acc_d1_reg;

    jls_line_buffer #(
        .LINE_DEPTH (LINE_DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_line_buffer (
        .aclk    (aclk),
        .ctrl    (lb_ctrl),
        .rd_addr (col_count_reg),
        .wr_data (cell_value),
        .wb_addr (a_col_reg),
        .mid_rd  (mid_rd),
        .up_rd   (up_rd)
    );

    // ------------------------------------------------------------------
    // Window chain. Entry 0 is the column now in the input stage; each cell
    // holds one earlier column and passes it on as the stream advances.
    // ------------------------------------------------------------------
    logic                  shift_en;
    logic [VALUE_BITS-1:0] win_mid [NCELLS+1];
    logic [VALUE_BITS-1:0] win_up  [NCELLS+1];
    logic [VALUE_BITS-1:0] win_cur [NCELLS+1];

    assign shift_en   = pipe_en && a_valid_reg;
    assign win_mid[0] = mid_rd;
    assign win_up[0]  = up_rd;
    assign win_cur[0] = a_cur_reg;

    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        jls_window_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .mid_in   (win_mid[i]),
            .up_in    (win_up[i]),
            .cur_in   (win_cur[i]),
            .mid_out  (win_mid[i+1]),
            .up_out   (win_up[i+1]),
            .cur_out  (win_cur[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Stencil stage: the four neighbors are summed exactly and truncated
    // by the shift. Up, old and down come from the column one left of the
    // input stage; left and right straddle it.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]      nb_sum;
    logic                  b_valid_reg;
    logic                  b_last_reg;
    logic                  b_first_reg;
    logic [VALUE_BITS-1:0] b_new_reg;
    logic [VALUE_BITS-1:0] b_old_reg;

    assign nb_sum = SUM_W'(win_up[1]) + SUM_W'(win_cur[1])
                  + SUM_W'(win_mid[2]) + SUM_W'(win_mid[0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            b_valid_reg <= a_valid_reg && a_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            b_new_reg   <= nb_sum[SUM_W-1:2];
            b_old_reg   <= win_mid[1];
            b_last_reg  <= a_last_reg;
            b_first_reg <= a_first_reg;
        end
    end

    // ------------------------------------------------------------------
    // Change and running maximum. The first interior result of a sweep
    // starts the maximum afresh, which also covers a restart by a
    // configuration write.
    // ------------------------------------------------------------------
    logic                  res_push;
    logic [VALUE_BITS-1:0] change;
    logic [VALUE_BITS-1:0] max_reg;
    logic [VALUE_BITS-1:0] max_next;
    logic [RES_W-1:0]      res_data;
    logic [RES_W-1:0]      out_data;

    assign res_push = pipe_en && b_valid_reg;
    assign change   = (b_new_reg >= b_old_reg) ? (b_new_reg - b_old_reg)
                                               : (b_old_reg - b_new_reg);

    always_comb begin
        max_next = max_reg;
        if (res_push) begin
            if (b_first_reg || (change > max_reg)) begin
                max_next = change;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= '0;
        end else begin
            max_reg <= max_next;
        end
    end

    assign res_data = {b_last_reg, max_next, change, b_new_reg};

    jls_output_skid #(
        .DATA_W (RES_W)
    ) u_output_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .room      (pipe_en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = M_DATA_W'(out_data[3*VALUE_BITS-1:0]);
    assign m_tlast = out_data[RES_W-1];

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `JLS_ASSERT(a_col_in_row, aclk, aresetn, col_count_reg <= w_last_reg, "column count past row end")
    `JLS_ASSERT(a_row_in_grid, aclk, aresetn, row_count_reg <= h_last_reg, "row count past grid end")
    `JLS_ASSERT_NEVER(a_push_when_full, aclk, aresetn, b_valid_reg && !pipe_en && $past(!pipe_en) && $past(b_valid_reg) && !$stable(b_new_reg), "stalled result changed")
    `JLS_ASSERT(a_stall_holds_output, aclk, aresetn, !pipe_en |-> m_tvalid, "skid full without a pending result")
    `JLS_ASSERT(a_writeback_follows, aclk, aresetn, lb_ctrl.wb_en |-> $past(s_accept), "line write-back without request")

endmodule

// ===== src/jls_line_buffer.sv =====
// Two line memories holding the two previous grid rows.
// Depends on jls_pkg for the control strobe struct and the default sizes.
`timescale 1ns / 1ps

module jls_line_buffer #(
    parameter int LINE_DEPTH = jls_pkg::DEF_LINE_DEPTH,
    parameter int VALUE_BITS = jls_pkg::DEF_VALUE_BITS,
    parameter int ADDR_W     = $clog2(LINE_DEPTH)
) (
    input  logic                  aclk,
    input  jls_pkg::lb_ctrl_t     ctrl,
    input  logic [ADDR_W-1:0]     rd_addr,
    input  logic [VALUE_BITS-1:0] wr_data,
    input  logic [ADDR_W-1:0]     wb_addr,
    output logic [VALUE_BITS-1:0] mid_rd,
    output logic [VALUE_BITS-1:0] up_rd
);

    logic [VALUE_BITS-1:0] mid_mem [LINE_DEPTH];
    logic [VALUE_BITS-1:0] up_mem  [LINE_DEPTH];
    logic [VALUE_BITS-1:0] mid_rd_reg;
    logic [VALUE_BITS-1:0] up_rd_reg;

    // The middle line is read before it is overwritten with the new row.
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            mid_rd_reg       <= mid_mem[rd_addr];
            mid_mem[rd_addr] <= wr_data;
        end
    end

    // The displaced middle entry moves to the upper line in the cycle after its read.
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            up_rd_reg <= up_mem[rd_addr];
        end
        if (ctrl.wb_en) begin
            up_mem[wb_addr] <= mid_rd_reg;
        end
    end

    assign mid_rd = mid_rd_reg;
    assign up_rd  = up_rd_reg;

endmodule

// ===== src/jls_window_cell.sv =====
// One column of the stencil window: middle row, upper row and current row.
// Depends on jls_pkg for the default width; cells are chained so each hands its column onward.
`timescale 1ns / 1ps

module jls_window_cell #(
    parameter int VALUE_BITS = jls_pkg::DEF_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  shift_en,
    input  logic [VALUE_BITS-1:0] mid_in,
    input  logic [VALUE_BITS-1:0] up_in,
    input  logic [VALUE_BITS-1:0] cur_in,
    output logic [VALUE_BITS-1:0] mid_out,
    output logic [VALUE_BITS-1:0] up_out,
    output logic [VALUE_BITS-1:0] cur_out
);

    logic [VALUE_BITS-1:0] mid_reg;
    logic [VALUE_BITS-1:0] up_reg;
    logic [VALUE_BITS-1:0] cur_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            mid_reg <= mid_in;
            up_reg  <= up_in;
            cur_reg <= cur_in;
        end
    end

    assign mid_out = mid_reg;
    assign up_out  = up_reg;
    assign cur_out = cur_reg;

endmodule

// ===== src/jls_output_skid.sv =====
// Output register with a skid entry, so the upstream stall is driven from a register.
// Depends on nothing.
`timescale 1ns / 1ps

module jls_output_skid #(
    parameter int DATA_W = 49
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              main_valid_reg;
    logic              main_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [DATA_W-1:0] main_data_reg;
    logic [DATA_W-1:0] main_data_next;
    logic [DATA_W-1:0] skid_data_reg;
    logic [DATA_W-1:0] skid_data_next;

    // Upstream only pushes while the skid entry is empty.
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_ready) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !out_ready) begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end else begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end
        end else if (out_ready) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign room      = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule
